// ----- hw/rtl/hlct_pkg.sv -----
// Shared types and constants for the honeycomb lattice cell translator.
// Holds the input and result word structs and the controller/datapath bundles.
// No dependencies.
package hlct_pkg;

	// Fixed field widths of the words and the register.
	localparam int CELL_W = 10;
	localparam int STEP_W = 8;
	localparam int CFG_W = 5;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_SIDE = 16;
	localparam int DEF_STEP_BITS = 8;

	// Side length after reset.
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;

	typedef struct packed {
		logic              action;
		logic [CELL_W-1:0] start_cell;
		logic              direction;
		logic [STEP_W-1:0] step_count;
	} in_word_t;

	typedef struct packed {
		logic [CELL_W-1:0] end_cell;
		logic              bad_cell;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic check;
		logic split_step;
		logic col_load;
		logic move_step;
		logic fin1;
		logic fin2;
		logic emit;
	} hlct_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad;
		logic split_done;
		logic cnt_zero;
	} hlct_stat_t;

endpackage

// ----- hw/rtl/hlct_ctrl.sv -----
// Sequencing state machine for the honeycomb lattice cell translator.
// Drives hlct_cmd_t commands into hlct_dpath and owns the handshakes.
// Depends on hlct_pkg.
module hlct_ctrl import hlct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  hlct_stat_t stat,
	output hlct_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_SPLIT = 3'd2;
	localparam logic [2:0] S_MOVE  = 3'd3;
	localparam logic [2:0] S_FIN1  = 3'd4;
	localparam logic [2:0] S_FIN2  = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d = stat.bad ? S_EMIT : S_SPLIT;
			end
			S_SPLIT: begin
				if (stat.split_done) begin
					cmd.col_load = 1'b1;
					state_d = S_MOVE;
				end else begin
					cmd.split_step = 1'b1;
				end
			end
			S_MOVE: begin
				if (stat.cnt_zero) begin
					state_d = S_FIN1;
				end else begin
					cmd.move_step = 1'b1;
				end
			end
			S_FIN1: begin
				cmd.fin1 = 1'b1;
				state_d = S_FIN2;
			end
			S_FIN2: begin
				cmd.fin2 = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				// The result register frees up when its word is taken.
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= cmd.emit | (out_valid_q & out_stall);
		end
	end

endmodule

// ----- hw/rtl/hlct_dpath.sv -----
// Datapath of the honeycomb lattice cell translator: side register, row walk,
// single-cell move unit, row-start arithmetic and the result register.
// Depends on hlct_pkg.
module hlct_dpath import hlct_pkg::*; #(
	parameter int MAX_SIDE = DEF_MAX_SIDE,
	parameter int STEP_BITS = DEF_STEP_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             lattice_size_we,
	input  logic [CFG_W-1:0] lattice_size,
	input  in_word_t         in_word,
	input  hlct_cmd_t        cmd,
	output hlct_stat_t       stat,
	output out_word_t        out_word
);

	// Side, row/column/length and index widths.
	localparam int NW = $clog2(MAX_SIDE + 1);
	localparam int RW = $clog2(3 * MAX_SIDE + 2);
	localparam int SW = RW + 1;
	localparam int TW = $clog2(3 * MAX_SIDE * MAX_SIDE + 2 * MAX_SIDE + 2) + 1;
	localparam int IW = (TW > CELL_W) ? TW : CELL_W;
	localparam int CNT_W = (STEP_BITS < STEP_W) ? STEP_BITS : STEP_W;

	logic [CFG_W-1:0] side_q;
	logic [NW-1:0]    n_sat;
	logic [NW-1:0]    n_q;
	logic [IW-1:0]    nsq_q;
	logic [IW-1:0]    cell_q;
	logic [IW-1:0]    base_q;
	logic [RW-1:0]    row_q;
	logic [RW-1:0]    col_q;
	logic [CNT_W-1:0] cnt_q;
	logic             back_q;
	logic             diag_q;
	logic             bad_q;
	logic [IW-1:0]    p1_q;
	logic [IW-1:0]    tri_q;
	logic [IW-1:0]    res_q;
	out_word_t        out_q;

	logic signed [SW-1:0] nn;
	logic signed [SW-1:0] rs;
	logic signed [SW-1:0] cs;
	logic signed [SW-1:0] len_cur;
	logic signed [SW-1:0] r1;
	logic signed [SW-1:0] c1;
	logic signed [SW-1:0] r2;
	logic [IW-1:0]        total;
	logic [IW-1:0]        idx;
	logic                 up;
	logic [RW-1:0]        a_v;
	logic [RW-1:0]        aa_v;
	logic [2*RW-1:0]      tri_prod;
	logic [RW+NW-1:0]     p1_prod;

	// Length of a row: n + r up to the middle row, 3n - r after it.
	function automatic logic signed [SW-1:0] row_len(input logic signed [SW-1:0] r,
		input logic signed [SW-1:0] n);
		logic signed [SW-1:0] n3;
		n3 = (n <<< 1) + n;
		return (r <= n) ? (r + n) : (n3 - r);
	endfunction

	// Side register; values beyond MAX_SIDE saturate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= CFG_RESET;
		end else if (lattice_size_we) begin
			side_q <= lattice_size;
		end
	end

	assign n_sat = (int'(side_q) > MAX_SIDE) ? NW'(MAX_SIDE) : NW'(side_q);

	assign nn = SW'(n_q);
	assign rs = SW'(row_q);
	assign cs = SW'(col_q);
	assign len_cur = row_len(rs, nn);

	// Cell count 3n^2 and the range check.
	assign total = (nsq_q << 1) + nsq_q;
	assign stat.bad = (n_q == '0) || (cell_q >= total);

	// Row walk: stop at the last row or when the cell lies in this row.
	assign stat.split_done = !((rs < (nn <<< 1) - SW'(1)) &&
		(cell_q >= base_q + IW'(len_cur[RW-1:0])));
	assign stat.cnt_zero = (cnt_q == '0);

	// One single-cell move on the current row and column.
	always_comb begin
		r1 = rs;
		c1 = cs;
		r2 = rs;
		if (!back_q) begin
			c1 = cs + SW'(1);
			if (diag_q) begin
				r1 = rs + SW'(1);
				if (r1 > nn) begin
					c1 = c1 - SW'(1);
				end
				if (r1 == (nn <<< 1)) begin
					r1 = '0;
				end
			end
			r2 = r1;
			if (c1 >= row_len(r1, nn)) begin
				r2 = (r1 >= nn) ? (r1 - nn) : (r1 + nn);
				c1 = '0;
			end
		end else begin
			c1 = cs - SW'(1);
			if (diag_q) begin
				r1 = rs - SW'(1);
				if (r1 < 0 || r1 >= nn) begin
					c1 = c1 + SW'(1);
				end
				if (r1 < 0) begin
					r1 = r1 + (nn <<< 1);
				end
			end
			r2 = r1;
			if (c1 < 0 || c1 >= row_len(r1, nn)) begin
				r2 = (r1 >= nn) ? (r1 - nn) : (r1 + nn);
				c1 = row_len(r2, nn) - SW'(1);
			end
		end
	end

	// Row start: r*n + r(r-1)/2 in the upper half, 3n^2 - m*n - m(m+1)/2 with
	// m = 2n - r in the lower half.
	assign up = (rs <= nn);
	assign a_v = up ? row_q : (RW'(n_q) << 1) - row_q;
	assign aa_v = up ? (a_v - RW'(1)) : (a_v + RW'(1));
	assign p1_prod = a_v * n_q;
	assign tri_prod = a_v * aa_v;
	assign idx = up ? (p1_q + tri_q + IW'(col_q)) : (total - p1_q - tri_q + IW'(col_q));

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= n_sat;
			nsq_q <= IW'(n_sat) * IW'(n_sat);
			cell_q <= IW'(in_word.start_cell);
			back_q <= in_word.action;
			diag_q <= in_word.direction;
			cnt_q <= in_word.step_count[CNT_W-1:0];
			base_q <= '0;
			row_q <= '0;
		end
		if (cmd.check) begin
			bad_q <= stat.bad;
		end
		if (cmd.split_step) begin
			base_q <= base_q + IW'(len_cur[RW-1:0]);
			row_q <= row_q + RW'(1);
		end
		if (cmd.col_load) begin
			col_q <= RW'(cell_q - base_q);
		end
		if (cmd.move_step) begin
			row_q <= r2[RW-1:0];
			col_q <= c1[RW-1:0];
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.fin1) begin
			p1_q <= IW'(p1_prod);
			tri_q <= IW'(tri_prod >> 1);
		end
		if (cmd.fin2) begin
			res_q <= idx;
		end
		if (cmd.emit) begin
			out_q.end_cell <= bad_q ? '0 : res_q[CELL_W-1:0];
			out_q.bad_cell <= bad_q;
		end
	end

	assign out_word = out_q;

endmodule

// ----- hw/rtl/hex_lattice_cell_translate_top.sv -----
// Top level of the honeycomb lattice cell translator.
// Instantiates hlct_ctrl and hlct_dpath; depends on hlct_pkg.
//
// Moves a unit cell on a hexagon-shaped honeycomb lattice of side n (register
// lattice_size, reset 2, saturating at MAX_SIDE) with periodic boundaries, one
// cell per step for step_count steps, and returns the final linear index.
// A start index at or beyond 3n^2, or a side of zero, gives bad_cell = 1 and
// end_cell = 0. One word is processed at a time: a valid start passes through
// the check, the row walk (one row per cycle, up to the row of the start
// cell), the moves (one move per cycle, step_count of them), two finishing
// steps and the emit; a bad start goes from the check straight to the emit.
// The result appears in the same cycle in which the next word can be accepted.
// The result sits in an output register, so a new word is taken while the previous
// result still waits.
module hex_lattice_cell_translate_top import hlct_pkg::*; #(
	parameter int MAX_SIDE = DEF_MAX_SIDE,
	parameter int STEP_BITS = DEF_STEP_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             lattice_size_we,
	input  logic [CFG_W-1:0] lattice_size,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word
);

	hlct_cmd_t  cmd;
	hlct_stat_t stat;

	hlct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	hlct_dpath #(
		.MAX_SIDE  (MAX_SIDE),
		.STEP_BITS (STEP_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.lattice_size_we (lattice_size_we),
		.lattice_size    (lattice_size),
		.in_word         (in_word),
		.cmd             (cmd),
		.stat            (stat),
		.out_word        (out_word)
	);

	// A bad start cell always reports index zero.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.bad_cell) |-> (out_word.end_cell == '0))
		else $error("bad cell result with nonzero index");

	// An accepted word keeps the input stalled in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a word is in progress");

	// A new result appears only from the busy sequence.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word appeared without a word in progress");

endmodule

// ----- bench/hex_lattice_cell_translate_top_tb.sv -----
// Self-checking testbench for the honeycomb lattice cell translator top level.
// Depends on hlct_pkg and hex_lattice_cell_translate_top; predicts every result
// word in a behavioral model of the lattice walk and compares it in order.
module hex_lattice_cell_translate_top_tb;
	import hlct_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SIDE = DEF_MAX_SIDE;
	localparam int STEP_BITS = DEF_STEP_BITS;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 400;

	// Field codes of the input word.
	localparam logic ACT_FWD = 1'b0;
	localparam logic ACT_BACK = 1'b1;
	localparam logic DIR_ROW = 1'b0;
	localparam logic DIR_DIAG = 1'b1;

	logic             clk;
	logic             arst_n;
	logic             lattice_size_we;
	logic [CFG_W-1:0] lattice_size;
	logic             in_valid;
	logic             in_stall;
	in_word_t         in_word;
	logic             out_valid;
	logic             out_stall;
	out_word_t        out_word;

	// Side length the block holds, mirrored for prediction.
	logic [CFG_W-1:0] side_cfg;
	out_word_t        expected_results[$];
	bit               idle_en;
	int               fail_count;
	int               checked_count;
	int               bad_start_count;
	int               side_writes;

	hex_lattice_cell_translate_top #(
		.MAX_SIDE(MAX_SIDE),
		.STEP_BITS(STEP_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.lattice_size_we(lattice_size_we),
		.lattice_size(lattice_size),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	// Free-running clock, 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Number of cells in a row of a lattice of side n.
	function automatic int row_cells(input int row, input int n);
		return (row <= n) ? (row + n) : (3 * n - row);
	endfunction

	// Linear index of the first cell of a row.
	function automatic int row_first(input int row, input int n);
		int sum;
		sum = 0;
		for (int k = 0; k < row; k++)
			sum += row_cells(k, n);
		return sum;
	endfunction

	// One single-cell move with periodic wrap of rows and columns.
	function automatic int step_cell(input int cell_idx, input int n, input bit back,
			input bit diag);
		int row;
		int col;
		int base;
		row = 0;
		base = 0;
		while (row < 2 * n - 1 && cell_idx >= base + row_cells(row, n)) begin
			base += row_cells(row, n);
			row++;
		end
		col = cell_idx - base;
		if (!back) begin
			col++;
			if (diag) begin
				row++;
				if (row > n)
					col--;
				row = row % (2 * n);
			end
			if (col >= row_cells(row, n)) begin
				row = (row >= n) ? row - n : row + n;
				col = 0;
			end
		end else begin
			col--;
			if (diag) begin
				row--;
				if (row < 0 || row >= n)
					col++;
				row = (row + 2 * n) % (2 * n);
			end
			if (col < 0 || col >= row_cells(row, n)) begin
				row = (row >= n) ? row - n : row + n;
				col = row_cells(row, n) - 1;
			end
		end
		return row_first(row, n) + col;
	endfunction

	// Expected result word for one input word under the given side setting.
	function automatic out_word_t predict_translate(input in_word_t w,
			input logic [CFG_W-1:0] side);
		out_word_t res;
		int n;
		int cur_idx;
		int steps;
		n = (int'(side) > MAX_SIDE) ? MAX_SIDE : int'(side);
		steps = int'(w.step_count) & ((1 << STEP_BITS) - 1);
		cur_idx = int'(w.start_cell);
		res = '0;
		if (n == 0 || cur_idx >= 3 * n * n) begin
			res.bad_cell = 1'b1;
			return res;
		end
		for (int i = 0; i < steps; i++)
			cur_idx = step_cell(cur_idx, n, w.action == ACT_BACK, w.direction == DIR_DIAG);
		res.end_cell = cur_idx[CELL_W-1:0];
		return res;
	endfunction

	function automatic in_word_t make_word(input logic act, input int start_idx,
			input logic dir, input int steps);
		in_word_t w;
		w.action = act;
		w.start_cell = start_idx[CELL_W-1:0];
		w.direction = dir;
		w.step_count = steps[STEP_W-1:0];
		return w;
	endfunction

	// Offer one word, optionally after a random gap, and log its prediction
	// at the edge where it is taken. Valid stays high on return.
	task automatic send_word(input in_word_t w);
		bit taken;
		out_word_t pred;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_word <= w;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		pred = predict_translate(w, side_cfg);
		expected_results.insert(expected_results.size(), pred);
		if (pred.bad_cell)
			bad_start_count++;
	endtask

	// Stop offering words and wait until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Register write; only called while the block is idle.
	task automatic set_side(input logic [CFG_W-1:0] side);
		lattice_size <= side;
		lattice_size_we <= 1'b1;
		@(posedge clk);
		lattice_size_we <= 1'b0;
		side_cfg = side;
		side_writes++;
	endtask

	// Random words for one side setting: mostly valid starts with short walks.
	task automatic run_side_phase(input logic [CFG_W-1:0] side, input int count);
		int n;
		int cells;
		int pick;
		int start_idx;
		int steps;
		set_side(side);
		n = (int'(side) > MAX_SIDE) ? MAX_SIDE : int'(side);
		cells = 3 * n * n;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (cells == 0 || pick == 0)
				start_idx = $urandom_range(0, 1023);
			else if (pick == 1) begin
				start_idx = cells - 2 + $urandom_range(0, 3);
				if (start_idx > 1023)
					start_idx = 1023;
			end else
				start_idx = $urandom_range(0, cells - 1);
			pick = $urandom_range(0, 9);
			if (pick < 7)
				steps = $urandom_range(0, 16);
			else if (pick < 9)
				steps = $urandom_range(0, 255);
			else
				steps = ($urandom_range(0, 1) == 1) ? 255 : 0;
			send_word(make_word(1'($urandom_range(0, 1)), start_idx,
				1'($urandom_range(0, 1)), steps));
		end
		drain_results();
	endtask

	// Reset side of two: row-end wraps, row wraps both ways, bad starts.
	task automatic test_reset_side();
		send_word(make_word(ACT_FWD, 0, DIR_ROW, 0));
		send_word(make_word(ACT_FWD, 1, DIR_ROW, 1));
		send_word(make_word(ACT_BACK, 0, DIR_ROW, 1));
		send_word(make_word(ACT_FWD, 8, DIR_DIAG, 1));
		send_word(make_word(ACT_FWD, 11, DIR_DIAG, 3));
		send_word(make_word(ACT_BACK, 0, DIR_DIAG, 2));
		send_word(make_word(ACT_BACK, 11, DIR_DIAG, 255));
		send_word(make_word(ACT_FWD, 12, DIR_ROW, 5));
		send_word(make_word(ACT_BACK, 1023, DIR_DIAG, 255));
		drain_results();
	endtask

	// Smallest and largest sides with the longest walks.
	task automatic test_side_extremes();
		set_side(5'd1);
		send_word(make_word(ACT_FWD, 2, DIR_DIAG, 7));
		send_word(make_word(ACT_BACK, 0, DIR_ROW, 255));
		send_word(make_word(ACT_FWD, 3, DIR_ROW, 1));
		drain_results();
		set_side(5'd16);
		send_word(make_word(ACT_FWD, 767, DIR_ROW, 255));
		send_word(make_word(ACT_BACK, 767, DIR_DIAG, 255));
		send_word(make_word(ACT_FWD, 0, DIR_DIAG, 255));
		send_word(make_word(ACT_BACK, 512, DIR_ROW, 17));
		send_word(make_word(ACT_FWD, 768, DIR_DIAG, 1));
		drain_results();
	endtask

	// A side of zero has no cells, so every start is bad.
	task automatic test_side_zero();
		set_side(5'd0);
		send_word(make_word(ACT_FWD, 0, DIR_ROW, 0));
		send_word(make_word(ACT_BACK, 767, DIR_DIAG, 255));
		drain_results();
	endtask

	// Sides beyond the maximum behave as the maximum.
	task automatic test_side_saturation();
		set_side(5'd31);
		send_word(make_word(ACT_FWD, 767, DIR_DIAG, 40));
		send_word(make_word(ACT_BACK, 768, DIR_ROW, 3));
		drain_results();
		set_side(5'd17);
		send_word(make_word(ACT_BACK, 700, DIR_ROW, 9));
		drain_results();
	endtask

	// Random words across a spread of side settings, with idling on both sides.
	task automatic test_random_sides();
		run_side_phase(5'd1, 185);
		run_side_phase(5'd16, 185);
		run_side_phase(5'd31, 185);
		run_side_phase(5'd3, 185);
		run_side_phase(CFG_W'($urandom_range(1, 31)), 185);
		run_side_phase(CFG_W'($urandom_range(1, 31)), 185);
		run_side_phase(5'd8, 185);
	endtask

	// Back-to-back words with no idling on either side.
	task automatic test_no_idle();
		idle_en = 1'b0;
		run_side_phase(CFG_W'($urandom_range(1, 16)), 200);
	endtask

	// Result checker and receiver stall generator.
	initial begin : result_check
		out_word_t want;
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word: end_cell %0d bad_cell %0d",
						out_word.end_cell, out_word.bad_cell);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (out_word.end_cell !== want.end_cell) begin
						$error("end_cell: expected %0d, actual %0d",
							want.end_cell, out_word.end_cell);
						fail_count++;
					end
					if (out_word.bad_cell !== want.bad_cell) begin
						$error("bad_cell: expected %0d, actual %0d",
							want.bad_cell, out_word.bad_cell);
						fail_count++;
					end
				end
			end
			@(posedge clk);
			// A stall burst always ends with out_stall low before another burst can start.
			if (idle_en && stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_en && !out_stall && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 13);
				out_stall <= 1'b1;
			end else begin
				stall_left = 0;
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run after too many cycles without any transfer.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog expired with %0d results outstanding.", expected_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		lattice_size_we = 1'b0;
		lattice_size = '0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		side_cfg = CFG_RESET;
		idle_en = 1'b1;
		fail_count = 0;
		checked_count = 0;
		bad_start_count = 0;
		side_writes = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_side();
		test_side_extremes();
		test_side_zero();
		test_side_saturation();
		test_random_sides();
		test_no_idle();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected result words never arrived", expected_results.size());
			fail_count++;
		end
		$display("Checked %0d result words (%0d with a bad start) over %0d side writes.",
			checked_count, bad_start_count, side_writes);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
